@@ design/rtv_pkg.sv @@
// Shared types, byte constants and helper functions of the request target validator.
// No dependencies; the scan unit and the top level use it by scoped names.
package rtv_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned NibW    = 4;
  localparam int unsigned StatusW = 4;
  localparam int unsigned ClassW  = 2;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned SegLenW = 2;

  localparam logic [LimitW-1:0] LimitReset = 16'd8192;

  localparam logic [ByteW-1:0] ChNonAscii  = 8'h80;
  localparam logic [ByteW-1:0] ChFirstVis  = 8'h21;
  localparam logic [ByteW-1:0] ChDel       = 8'h7f;
  localparam logic [ByteW-1:0] ChSlash     = 8'h2f;
  localparam logic [ByteW-1:0] ChBackslash = 8'h5c;
  localparam logic [ByteW-1:0] ChHash      = 8'h23;
  localparam logic [ByteW-1:0] ChPercent   = 8'h25;
  localparam logic [ByteW-1:0] ChQuestion  = 8'h3f;
  localparam logic [ByteW-1:0] ChDot       = 8'h2e;

  typedef enum logic [StatusW-1:0] {
    StOk           = 4'd0,
    StTooLong      = 4'd1,
    StNotOrigin    = 4'd2,
    StBadByte      = 4'd3,
    StBackslash    = 4'd4,
    StBadEscape    = 4'd5,
    StEncodedSlash = 4'd6,
    StDotSegment   = 4'd7,
    StEncodedDot   = 4'd8
  } status_e;

  typedef enum logic [ClassW-1:0] {
    ClsAccepted = 2'd0,
    ClsInvalid  = 2'd1,
    ClsResource = 2'd2
  } err_class_e;

  typedef enum logic [1:0] {
    FbeNone    = 2'd0,
    FbeControl = 2'd1,
    FbeSpecial = 2'd2
  } byte_err_e;

  typedef enum logic [1:0] {
    EscIdle = 2'd0,
    EscHigh = 2'd1,
    EscLow  = 2'd2
  } esc_phase_e;

  typedef enum logic [1:0] {
    DotNone = 2'd0,
    DotRaw  = 2'd1,
    DotEnc  = 2'd2
  } dot_err_e;

  typedef struct packed {
    logic            valid;
    logic [NibW-1:0] value;
  } nibble_t;

  typedef struct packed {
    logic       fire;
    status_e    status;
    err_class_e err_class;
  } result_t;

  function automatic nibble_t hex_nibble(logic [ByteW-1:0] b);
    nibble_t n;
    n.valid = 1'b1;
    n.value = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      n.value = NibW'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      n.value = NibW'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      n.value = NibW'(b - 8'h37);
    end else begin
      n.valid = 1'b0;
    end
    return n;
  endfunction

  function automatic err_class_e class_of(status_e s);
    err_class_e c;
    unique case (s)
      StOk:      c = ClsAccepted;
      StTooLong: c = ClsResource;
      default:   c = ClsInvalid;
    endcase
    return c;
  endfunction

endpackage

@@ design/rtv_scan.sv @@
// Per-target scan state and its one-byte update, with the final status check.
// Depends on rtv_pkg.
module rtv_scan #(
  parameter int unsigned COUNT_WIDTH = 17
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [rtv_pkg::ByteW-1:0]   text_byte_i,
  input  logic                        end_of_target_i,
  input  logic                        empty_target_i,
  input  logic [rtv_pkg::LimitW-1:0]  max_target_bytes_i,
  output rtv_pkg::result_t            result_o
);

  localparam int unsigned CmpW = (COUNT_WIDTH > rtv_pkg::LimitW) ? COUNT_WIDTH : rtv_pkg::LimitW;

  logic [COUNT_WIDTH-1:0]      count_q, count_d;
  logic                        origin_bad_q, origin_bad_d;
  rtv_pkg::byte_err_e          fbe_q, fbe_d;
  logic                        esc_bad_q, esc_bad_d;
  rtv_pkg::esc_phase_e         phase_q, phase_d;
  logic [rtv_pkg::NibW-1:0]    high_q, high_d;
  logic                        in_query_q, in_query_d;
  logic                        enc_slash_q, enc_slash_d;
  logic [rtv_pkg::SegLenW-1:0] seg_len_q, seg_len_d;
  logic                        seg_dots_q, seg_dots_d;
  logic                        seg_esc_q, seg_esc_d;
  rtv_pkg::dot_err_e           dot_err_q, dot_err_d;

  always_comb begin
    rtv_pkg::nibble_t         nib;
    logic [rtv_pkg::ByteW-1:0] dec;
    logic                     plain;
    logic                     finish;
    rtv_pkg::status_e         st;

    count_d     = count_q;
    origin_bad_d = origin_bad_q;
    fbe_d       = fbe_q;
    esc_bad_d   = esc_bad_q;
    phase_d     = phase_q;
    high_d      = high_q;
    in_query_d  = in_query_q;
    enc_slash_d = enc_slash_q;
    seg_len_d   = seg_len_q;
    seg_dots_d  = seg_dots_q;
    seg_esc_d   = seg_esc_q;
    dot_err_d   = dot_err_q;
    nib         = rtv_pkg::hex_nibble(text_byte_i);
    dec         = {high_q, nib.value};
    plain       = 1'b0;
    finish      = end_of_target_i || empty_target_i;
    st          = rtv_pkg::StOk;

    if (!empty_target_i) begin
      if (count_q == '0 && text_byte_i != rtv_pkg::ChSlash) begin
        origin_bad_d = 1'b1;
      end
      if (count_q != '1) begin
        count_d = count_q + COUNT_WIDTH'(1);
      end
      if (fbe_q == rtv_pkg::FbeNone) begin
        if (text_byte_i >= rtv_pkg::ChNonAscii || text_byte_i < rtv_pkg::ChFirstVis ||
            text_byte_i == rtv_pkg::ChDel) begin
          fbe_d = rtv_pkg::FbeControl;
        end else if (text_byte_i == rtv_pkg::ChBackslash || text_byte_i == rtv_pkg::ChHash) begin
          fbe_d = rtv_pkg::FbeSpecial;
        end
      end

      if (phase_q == rtv_pkg::EscIdle) begin
        plain = 1'b1;
      end else if (nib.valid && phase_q == rtv_pkg::EscHigh) begin
        high_d  = nib.value;
        phase_d = rtv_pkg::EscLow;
      end else if (nib.valid) begin
        phase_d = rtv_pkg::EscIdle;
        if (!in_query_q) begin
          if (dec == rtv_pkg::ChSlash || dec == rtv_pkg::ChBackslash) begin
            enc_slash_d = 1'b1;
          end
          if (seg_len_q != '1) begin
            seg_len_d = seg_len_q + rtv_pkg::SegLenW'(1);
          end
          if (dec != rtv_pkg::ChDot) begin
            seg_dots_d = 1'b0;
          end
          seg_esc_d = 1'b1;
        end
      end else begin
        esc_bad_d = 1'b1;
        phase_d   = rtv_pkg::EscIdle;
        plain     = 1'b1;
      end

      if (plain) begin
        if (text_byte_i == rtv_pkg::ChPercent) begin
          phase_d = rtv_pkg::EscHigh;
        end else if (!in_query_q) begin
          if (text_byte_i == rtv_pkg::ChSlash || text_byte_i == rtv_pkg::ChQuestion) begin
            if (dot_err_d == rtv_pkg::DotNone && seg_dots_d && seg_len_d != '0 &&
                seg_len_d != '1) begin
              dot_err_d = seg_esc_d ? rtv_pkg::DotEnc : rtv_pkg::DotRaw;
            end
            seg_len_d  = '0;
            seg_dots_d = 1'b1;
            seg_esc_d  = 1'b0;
            if (text_byte_i == rtv_pkg::ChQuestion) begin
              in_query_d = 1'b1;
            end
          end else begin
            if (seg_len_q != '1) begin
              seg_len_d = seg_len_q + rtv_pkg::SegLenW'(1);
            end
            if (text_byte_i != rtv_pkg::ChDot) begin
              seg_dots_d = 1'b0;
            end
          end
        end
      end
    end

    if (finish) begin
      if (phase_d != rtv_pkg::EscIdle) begin
        esc_bad_d = 1'b1;
      end
      if (!in_query_d && dot_err_d == rtv_pkg::DotNone && seg_dots_d && seg_len_d != '0 &&
          seg_len_d != '1) begin
        dot_err_d = seg_esc_d ? rtv_pkg::DotEnc : rtv_pkg::DotRaw;
      end

      if (CmpW'(count_d) > CmpW'(max_target_bytes_i)) begin
        st = rtv_pkg::StTooLong;
      end else if (count_d == '0 || origin_bad_d) begin
        st = rtv_pkg::StNotOrigin;
      end else if (fbe_d == rtv_pkg::FbeControl) begin
        st = rtv_pkg::StBadByte;
      end else if (fbe_d == rtv_pkg::FbeSpecial) begin
        st = rtv_pkg::StBackslash;
      end else if (esc_bad_d) begin
        st = rtv_pkg::StBadEscape;
      end else if (enc_slash_d) begin
        st = rtv_pkg::StEncodedSlash;
      end else if (dot_err_d == rtv_pkg::DotRaw) begin
        st = rtv_pkg::StDotSegment;
      end else if (dot_err_d == rtv_pkg::DotEnc) begin
        st = rtv_pkg::StEncodedDot;
      end

      count_d      = '0;
      origin_bad_d = 1'b0;
      fbe_d        = rtv_pkg::FbeNone;
      esc_bad_d    = 1'b0;
      phase_d      = rtv_pkg::EscIdle;
      high_d       = '0;
      in_query_d   = 1'b0;
      enc_slash_d  = 1'b0;
      seg_len_d    = '0;
      seg_dots_d   = 1'b1;
      seg_esc_d    = 1'b0;
      dot_err_d    = rtv_pkg::DotNone;
    end

    result_o.fire      = step_i && finish;
    result_o.status    = st;
    result_o.err_class = rtv_pkg::class_of(st);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      origin_bad_q <= 1'b0;
      fbe_q        <= rtv_pkg::FbeNone;
      esc_bad_q    <= 1'b0;
      phase_q      <= rtv_pkg::EscIdle;
      high_q       <= '0;
      in_query_q   <= 1'b0;
      enc_slash_q  <= 1'b0;
      seg_len_q    <= '0;
      seg_dots_q   <= 1'b1;
      seg_esc_q    <= 1'b0;
      dot_err_q    <= rtv_pkg::DotNone;
    end else if (step_i) begin
      count_q      <= count_d;
      origin_bad_q <= origin_bad_d;
      fbe_q        <= fbe_d;
      esc_bad_q    <= esc_bad_d;
      phase_q      <= phase_d;
      high_q       <= high_d;
      in_query_q   <= in_query_d;
      enc_slash_q  <= enc_slash_d;
      seg_len_q    <= seg_len_d;
      seg_dots_q   <= seg_dots_d;
      seg_esc_q    <= seg_esc_d;
      dot_err_q    <= dot_err_d;
    end
  end

endmodule

@@ design/request_target_validator.sv @@
// Top level of the request target validator: input register, limit register and result register.
// Depends on rtv_pkg and rtv_scan.
//
//   Channel   Signals                                        Direction
//   request   in_valid_i / in_ready_o, text_byte_i,          in
//             end_of_target_i, empty_target_i
//   result    out_valid_o / out_ready_i, status_o,           out
//             error_class_o
//   config    cfg_we_i, cfg_wdata_i (max_target_bytes)       in
//
// One request is taken per cycle while in_ready_o is high; a target's scan result sets out_valid_o.
// The scan state advances once per cycle when the input register holds a request and the result
// register is free or being emptied. Reset clears all valid flags and scan state and sets the
// limit to 8192; a stalled result holds the input register and in turn in_ready_o.
module request_target_validator #(
  parameter int unsigned COUNT_WIDTH = 17
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rtv_pkg::ByteW-1:0]         text_byte_i,
  input  logic                              end_of_target_i,
  input  logic                              empty_target_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rtv_pkg::StatusW-1:0]       status_o,
  output logic [rtv_pkg::ClassW-1:0]        error_class_o,
  input  logic                              cfg_we_i,
  input  logic [rtv_pkg::LimitW-1:0]        cfg_wdata_i
);

  logic                             in_valid_q;
  logic [rtv_pkg::ByteW-1:0]        byte_q;
  logic                             end_q;
  logic                             empty_q;
  logic [rtv_pkg::LimitW-1:0]       limit_q;
  logic                             out_valid_q, out_valid_d;
  rtv_pkg::status_e                 status_q;
  rtv_pkg::err_class_e              class_q;
  logic                             advance;
  rtv_pkg::result_t                 result;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  rtv_scan #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_scan (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (advance),
    .text_byte_i        (byte_q),
    .end_of_target_i    (end_q),
    .empty_target_i     (empty_q),
    .max_target_bytes_i (limit_q),
    .result_o           (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (result.fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= rtv_pkg::LimitReset;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= text_byte_i;
      end_q   <= end_of_target_i;
      empty_q <= empty_target_i;
    end
    if (result.fire) begin
      status_q <= result.status;
      class_q  <= result.err_class;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign error_class_o = class_q;

endmodule

@@ tb/request_target_validator_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of request_target_validator: directed table, boundary-length targets
// and random targets under several length limits, with bursty requests and a stalling sink.
// Depends on rtv_pkg and the request_target_validator design files.
module request_target_validator_test;

  localparam int unsigned COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam int unsigned PHASES = 6;
  localparam int unsigned PER_PHASE = 160;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_STALL = 400;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DIR_ROWS = 24;

  typedef struct {
    logic [COUNT_W-1:0]          n_bytes;
    bit                          origin_bad;
    rtv_pkg::byte_err_e          byte_err;
    bit                          esc_bad;
    rtv_pkg::esc_phase_e         phase;
    logic [rtv_pkg::NibW-1:0]    hi;
    bit                          in_query;
    bit                          enc_slash;
    logic [rtv_pkg::SegLenW-1:0] seg_len;
    bit                          seg_dots;
    bit                          seg_esc;
    rtv_pkg::dot_err_e           dot;
  } scan_state_t;

  typedef struct {
    rtv_pkg::status_e    st;
    rtv_pkg::err_class_e cls;
  } verdict_t;

  typedef struct {
    logic [rtv_pkg::ByteW-1:0] b;
    bit                        eot;
    bit                        emp;
    bit                        typed;
    rtv_pkg::status_e          st;
  } dir_row_t;

  typedef enum int {
    SinkOpen,
    SinkHalf,
    SinkSparse,
    SinkPattern,
    SinkMostly
  } sink_mode_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [rtv_pkg::ByteW-1:0]     text_byte_i;
  logic                          end_of_target_i;
  logic                          empty_target_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [rtv_pkg::StatusW-1:0]   status_o;
  logic [rtv_pkg::ClassW-1:0]    error_class_o;
  logic                          cfg_we_i;
  logic [rtv_pkg::LimitW-1:0]    cfg_wdata_i;

  scan_state_t                scan;
  logic [rtv_pkg::LimitW-1:0] limit_shadow;
  verdict_t                   pending_verdicts[$];
  logic [rtv_pkg::ByteW-1:0]  tgt_bytes[$];
  dir_row_t                   dir_rows[DIR_ROWS];
  int unsigned                mismatches;
  int unsigned                cycle_count;
  int unsigned                burst_left;
  int unsigned                gap_left;
  int unsigned                random_sent;
  bit                         long_stall_due;

  request_target_validator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .text_byte_i     (text_byte_i),
    .end_of_target_i (end_of_target_i),
    .empty_target_i  (empty_target_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .error_class_o   (error_class_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void clear_scan();
    scan.n_bytes    = '0;
    scan.origin_bad = 1'b0;
    scan.byte_err   = rtv_pkg::FbeNone;
    scan.esc_bad    = 1'b0;
    scan.phase      = rtv_pkg::EscIdle;
    scan.hi         = '0;
    scan.in_query   = 1'b0;
    scan.enc_slash  = 1'b0;
    scan.seg_len    = '0;
    scan.seg_dots   = 1'b1;
    scan.seg_esc    = 1'b0;
    scan.dot        = rtv_pkg::DotNone;
  endfunction

  function automatic void decode_hex(input logic [rtv_pkg::ByteW-1:0] b, output bit ok,
                                     output logic [rtv_pkg::NibW-1:0] v);
    ok = 1'b1;
    v = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b[3:0];
    end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
      v = b[3:0] + 4'd9;
    end else begin
      ok = 1'b0;
    end
  endfunction

  function automatic void add_unit(input bit is_dot, input bit escaped);
    if (scan.seg_len != 2'd3) scan.seg_len = scan.seg_len + 2'd1;
    if (!is_dot) scan.seg_dots = 1'b0;
    if (escaped) scan.seg_esc = 1'b1;
  endfunction

  function automatic void close_segment();
    if (scan.dot == rtv_pkg::DotNone && scan.seg_dots &&
        scan.seg_len >= 2'd1 && scan.seg_len <= 2'd2) begin
      scan.dot = scan.seg_esc ? rtv_pkg::DotEnc : rtv_pkg::DotRaw;
    end
    scan.seg_len  = '0;
    scan.seg_dots = 1'b1;
    scan.seg_esc  = 1'b0;
  endfunction

  function automatic void scan_byte(input logic [rtv_pkg::ByteW-1:0] b);
    bit                        nib_ok;
    logic [rtv_pkg::NibW-1:0]  nib;
    logic [rtv_pkg::ByteW-1:0] dec;
    if (scan.n_bytes == '0 && b != rtv_pkg::ChSlash) scan.origin_bad = 1'b1;
    if (scan.n_bytes != COUNT_MAX) scan.n_bytes = scan.n_bytes + 1'b1;
    if (scan.byte_err == rtv_pkg::FbeNone) begin
      if (b >= rtv_pkg::ChNonAscii || b < rtv_pkg::ChFirstVis || b == rtv_pkg::ChDel) begin
        scan.byte_err = rtv_pkg::FbeControl;
      end else if (b == rtv_pkg::ChBackslash || b == rtv_pkg::ChHash) begin
        scan.byte_err = rtv_pkg::FbeSpecial;
      end
    end
    decode_hex(b, nib_ok, nib);
    if (scan.phase != rtv_pkg::EscIdle) begin
      if (nib_ok && scan.phase == rtv_pkg::EscHigh) begin
        scan.hi = nib;
        scan.phase = rtv_pkg::EscLow;
        return;
      end
      if (nib_ok) begin
        dec = {scan.hi, nib};
        scan.phase = rtv_pkg::EscIdle;
        if (!scan.in_query) begin
          if (dec == rtv_pkg::ChSlash || dec == rtv_pkg::ChBackslash) scan.enc_slash = 1'b1;
          add_unit(dec == rtv_pkg::ChDot, 1'b1);
        end
        return;
      end
      scan.esc_bad = 1'b1;
      scan.phase = rtv_pkg::EscIdle;
    end
    if (b == rtv_pkg::ChPercent) begin
      scan.phase = rtv_pkg::EscHigh;
      return;
    end
    if (scan.in_query) return;
    if (b == rtv_pkg::ChSlash) begin
      close_segment();
    end else if (b == rtv_pkg::ChQuestion) begin
      close_segment();
      scan.in_query = 1'b1;
    end else begin
      add_unit(b == rtv_pkg::ChDot, 1'b0);
    end
  endfunction

  function automatic rtv_pkg::status_e judge_target();
    if (scan.phase != rtv_pkg::EscIdle) scan.esc_bad = 1'b1;
    if (!scan.in_query) close_segment();
    if (scan.n_bytes > {1'b0, limit_shadow}) return rtv_pkg::StTooLong;
    if (scan.n_bytes == '0 || scan.origin_bad) return rtv_pkg::StNotOrigin;
    if (scan.byte_err == rtv_pkg::FbeControl) return rtv_pkg::StBadByte;
    if (scan.byte_err == rtv_pkg::FbeSpecial) return rtv_pkg::StBackslash;
    if (scan.esc_bad) return rtv_pkg::StBadEscape;
    if (scan.enc_slash) return rtv_pkg::StEncodedSlash;
    if (scan.dot == rtv_pkg::DotRaw) return rtv_pkg::StDotSegment;
    if (scan.dot == rtv_pkg::DotEnc) return rtv_pkg::StEncodedDot;
    return rtv_pkg::StOk;
  endfunction

  function automatic rtv_pkg::err_class_e class_for(input rtv_pkg::status_e st);
    if (st == rtv_pkg::StOk) return rtv_pkg::ClsAccepted;
    if (st == rtv_pkg::StTooLong) return rtv_pkg::ClsResource;
    return rtv_pkg::ClsInvalid;
  endfunction

  function automatic void advance_scan(input logic [rtv_pkg::ByteW-1:0] b, input bit eot,
                                       input bit emp, output bit done,
                                       output rtv_pkg::status_e st);
    done = 1'b0;
    st = rtv_pkg::StOk;
    if (!emp) scan_byte(b);
    if (eot || emp) begin
      st = judge_target();
      done = 1'b1;
      clear_scan();
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic compare_verdict();
    verdict_t want;
    if (pending_verdicts.size() == 0) begin
      flag_mismatch($sformatf("unexpected result status %0d class %0d", status_o, error_class_o));
    end else begin
      want = pending_verdicts.pop_front();
      if (status_o !== want.st) begin
        flag_mismatch($sformatf("status %0d, expected %0d", status_o, want.st));
      end
      if (error_class_o !== want.cls) begin
        flag_mismatch($sformatf("error class %0d, expected %0d", error_class_o, want.cls));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) compare_verdict();
  end

  // Result sink: switches between randomly chosen stall patterns, and holds off for a long
  // stretch once when asked so that the block backs up into its request side.
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned left;
    mode = SinkOpen;
    left = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_stall_due) begin
        out_ready_i <= 1'b0;
        repeat (LONG_STALL) @(posedge clk_i);
        long_stall_due = 1'b0;
      end
      if (left == 0) begin
        mode = sink_mode_e'($urandom_range(SinkOpen, SinkMostly));
        left = $urandom_range(10, 80);
      end
      left--;
      case (mode)
        SinkOpen:    out_ready_i <= 1'b1;
        SinkHalf:    out_ready_i <= 1'($urandom_range(0, 1));
        SinkSparse:  out_ready_i <= ($urandom_range(0, 3) == 0);
        SinkPattern: out_ready_i <= (cycle_count[1:0] != 2'b00);
        default:     out_ready_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic offer(input logic [rtv_pkg::ByteW-1:0] b, input bit eot, input bit emp,
                       input bit typed, input rtv_pkg::status_e typed_st);
    bit               done;
    rtv_pkg::status_e st;
    verdict_t         v;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      while (gap_left > 0) begin
        @(posedge clk_i);
        gap_left--;
      end
    end
    in_valid_i      <= 1'b1;
    text_byte_i     <= b;
    end_of_target_i <= eot;
    empty_target_i  <= emp;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    advance_scan(b, eot, emp, done, st);
    if (done) begin
      if (typed) st = typed_st;
      v.st = st;
      v.cls = class_for(st);
      pending_verdicts.insert(pending_verdicts.size(), v);
    end
  endtask

  task automatic wait_drained();
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [rtv_pkg::LimitW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    limit_shadow = value;
  endtask

  task automatic send_long_target(input int unsigned n);
    int unsigned k;
    offer(rtv_pkg::ChSlash, n == 1, 1'b0, 1'b0, rtv_pkg::StOk);
    for (k = 1; k < n; k++) begin
      offer(8'h61 + 8'($urandom_range(0, 25)), k == n - 1, 1'b0, 1'b0, rtv_pkg::StOk);
    end
  endtask

  function automatic logic [rtv_pkg::ByteW-1:0] hex_char(input int unsigned v, input bit upper);
    if (v < 10) return 8'h30 + v[7:0];
    return (upper ? 8'h37 : 8'h57) + v[7:0];
  endfunction

  function automatic logic [rtv_pkg::ByteW-1:0] plain_char();
    if ($urandom_range(0, 3) == 0) return 8'h30 + 8'($urandom_range(0, 9));
    return 8'h61 + 8'($urandom_range(0, 25));
  endfunction

  function automatic void append_byte(input logic [rtv_pkg::ByteW-1:0] b);
    tgt_bytes.insert(tgt_bytes.size(), b);
  endfunction

  task automatic build_target();
    int unsigned units;
    int unsigned pick;
    int unsigned k;
    int unsigned sel;
    bit          upper;
    tgt_bytes.delete();
    units = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 10);
    if ($urandom_range(0, 11) != 0) append_byte(rtv_pkg::ChSlash);
    else append_byte(8'($urandom_range(0, 255)));
    for (k = 0; k < units; k++) begin
      pick = $urandom_range(0, 99);
      upper = 1'($urandom_range(0, 1));
      if (pick < 16) begin
        append_byte(rtv_pkg::ChSlash);
      end else if (pick < 32) begin
        append_byte(rtv_pkg::ChDot);
      end else if (pick < 56) begin
        append_byte(plain_char());
      end else if (pick < 70) begin
        append_byte(rtv_pkg::ChPercent);
        sel = $urandom_range(0, 3);
        append_byte(sel == 0 ? 8'h32 : sel == 1 ? 8'h35 :
                    hex_char($urandom_range(0, 15), upper));
        sel = $urandom_range(0, 3);
        append_byte(sel == 0 ? hex_char(14, upper) : sel == 1 ? hex_char(15, upper) :
                    sel == 2 ? hex_char(12, upper) :
                    hex_char($urandom_range(0, 15), upper));
      end else if (pick < 75) begin
        append_byte(rtv_pkg::ChQuestion);
      end else if (pick < 79) begin
        append_byte(rtv_pkg::ChPercent);
        if ($urandom_range(0, 1)) append_byte(hex_char($urandom_range(0, 15), upper));
        if ($urandom_range(0, 1)) append_byte(8'h67 + 8'($urandom_range(0, 19)));
      end else if (pick < 82) begin
        append_byte($urandom_range(0, 1) ? rtv_pkg::ChHash : rtv_pkg::ChBackslash);
      end else if (pick < 85) begin
        append_byte(8'($urandom_range(0, 255)));
      end else if (pick < 87) begin
        append_byte($urandom_range(0, 1) ? rtv_pkg::ChDel : 8'h00 + 8'($urandom_range(0, 32)));
      end else begin
        append_byte(plain_char());
      end
    end
  endtask

  task automatic send_random_target();
    int unsigned style;
    int unsigned k;
    build_target();
    style = $urandom_range(0, 99);
    if (style < 6) begin
      offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, rtv_pkg::StOk);
      random_sent++;
    end else begin
      for (k = 0; k < tgt_bytes.size(); k++) begin
        offer(tgt_bytes[k], style < 84 && k == tgt_bytes.size() - 1, 1'b0, 1'b0, rtv_pkg::StOk);
        random_sent++;
      end
      if (style >= 84) begin
        offer(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1, 1'b0, rtv_pkg::StOk);
        random_sent++;
      end
    end
  endtask

  function automatic logic [rtv_pkg::LimitW-1:0] limit_for_phase(input int unsigned p);
    case (p)
      0:       return 16'd1;
      1:       return 16'd0;
      2:       return 16'($urandom_range(2, 30));
      3:       return 16'hFFFF;
      4:       return 16'($urandom_range(1, 65535));
      default: return 16'($urandom_range(2, 12));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned                r;
    int unsigned                p;
    logic [rtv_pkg::LimitW-1:0] lim;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    text_byte_i     = '0;
    end_of_target_i = 1'b0;
    empty_target_i  = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    mismatches      = 0;
    cycle_count     = 0;
    burst_left      = 0;
    gap_left        = 0;
    random_sent     = 0;
    long_stall_due  = 1'b0;
    limit_shadow    = rtv_pkg::LimitReset;
    clear_scan();

    dir_rows = '{
      '{8'hFF,                1'b0, 1'b1, 1'b1, rtv_pkg::StNotOrigin},
      '{8'h00,                1'b1, 1'b0, 1'b1, rtv_pkg::StNotOrigin},
      '{rtv_pkg::ChSlash,     1'b0, 1'b0, 1'b0, rtv_pkg::StOk},
      '{8'hFF,                1'b1, 1'b0, 1'b1, rtv_pkg::StBadByte},
      '{rtv_pkg::ChSlash,     1'b0, 1'b0, 1'b0, rtv_pkg::StOk},
      '{rtv_pkg::ChBackslash, 1'b1, 1'b0, 1'b1, rtv_pkg::StBackslash},
      '{rtv_pkg::ChSlash,     1'b0, 1'b0, 1'b0, rtv_pkg::StOk},
      '{rtv_pkg::ChPercent,   1'b0, 1'b0, 1'b0, rtv_pkg::StOk},
      '{8'h32,                1'b1, 1'b0, 1'b1, rtv_pkg::StBadEscape},
      '{rtv_pkg::ChSlash,     1'b0, 1'b0, 1'b0, rtv_pkg::StOk},
      '{rtv_pkg::ChPercent,   1'b0, 1'b0, 1'b0, rtv_pkg::StOk},
      '{8'h67,                1'b1, 1'b0, 1'b1, rtv_pkg::StBadEscape},
      '{rtv_pkg::ChSlash,     1'b0, 1'b0, 1'b0, rtv_pkg::StOk},
      '{rtv_pkg::ChPercent,   1'b0, 1'b0, 1'b0, rtv_pkg::StOk},
      '{8'h32,                1'b0, 1'b0, 1'b0, rtv_pkg::StOk},
      '{8'h46,                1'b1, 1'b0, 1'b1, rtv_pkg::StEncodedSlash},
      '{rtv_pkg::ChSlash,     1'b0, 1'b0, 1'b0, rtv_pkg::StOk},
      '{rtv_pkg::ChDot,       1'b1, 1'b0, 1'b1, rtv_pkg::StDotSegment},
      '{rtv_pkg::ChSlash,     1'b0, 1'b0, 1'b0, rtv_pkg::StOk},
      '{rtv_pkg::ChPercent,   1'b0, 1'b0, 1'b0, rtv_pkg::StOk},
      '{8'h32,                1'b0, 1'b0, 1'b0, rtv_pkg::StOk},
      '{8'h65,                1'b1, 1'b0, 1'b1, rtv_pkg::StEncodedDot},
      '{rtv_pkg::ChSlash,     1'b0, 1'b0, 1'b0, rtv_pkg::StOk},
      '{8'h41,                1'b1, 1'b1, 1'b1, rtv_pkg::StOk}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < DIR_ROWS; r++) begin
      offer(dir_rows[r].b, dir_rows[r].eot, dir_rows[r].emp, dir_rows[r].typed, dir_rows[r].st);
    end
    in_valid_i <= 1'b0;

    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      lim = limit_for_phase(p);
      write_limit(lim);
      if (p == 2) begin
        // Targets exactly at the limit and one byte past it.
        send_long_target(32'(lim));
        send_long_target(32'(lim) + 1);
        long_stall_due = 1'b1;
      end
      while (random_sent < (p + 1) * PER_PHASE) send_random_target();
      in_valid_i <= 1'b0;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/rtv_pkg.sv
design/rtv_scan.sv
design/request_target_validator.sv
tb/request_target_validator_test.sv
